// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ort_pkg.sv =====
package ort_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int ENTRY_WIDTH_DEF = 64;

    localparam int REQ_W    = 2;
    localparam int ENTRY_W  = 64;
    localparam int ROOM_W   = 16;
    localparam int CAP_W    = 7;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;

    localparam int CAP_RESET = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_DRAIN  = 2'd2,
        REQ_RESET  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NO_ROOM   = 2'd2,
        ST_OVERWRITE = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_entry;
        logic entry_last;
        logic drain_step;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
        logic start_remove;
        logic start_drain;
        logic drain_last;
    } t_dp_status;

endpackage

// ===== hdl/ort_ram.sv =====
module ort_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ort_datapath.sv =====
module ort_datapath import ort_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_W-1:0]    i_capacity,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [ENTRY_W-1:0]  i_entry_in,
    input  logic [ROOM_W-1:0]   i_reader_room,
    input  t_ctl_cmd            i_cmd,
    output t_dp_status          o_status,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ENTRY_W-1:0]  o_entry_out,
    output logic                o_entry_valid,
    output logic                o_last,
    output logic [STATUS_W-1:0] o_status_code,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_is_full,
    output logic                o_is_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int XW = ((PW > CAP_W) ? PW : CAP_W) + 1;
    localparam logic [CAP_W-1:0] CAP_INIT =
        (DEPTH < CAP_RESET) ? CAP_W'(DEPTH) : CAP_W'(CAP_RESET);

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p,
                                             input logic [CAP_W-1:0] cap);
        logic [XW-1:0] n;
        n = XW'(p) + XW'(1);
        f_next = (n >= XW'(cap)) ? '0 : n[PW-1:0];
    endfunction

    logic [CAP_W-1:0] r_cap, n_cap;
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic             r_full, n_full;
    logic [PW-1:0]    r_da, n_da;
    logic [OCC_W-1:0] r_cnt, n_cnt;

    logic               r_out_valid;
    logic [ENTRY_W-1:0] r_entry_out;
    logic               r_entry_valid;
    logic               r_last;
    t_status            r_status;
    logic [OCC_W-1:0]   r_occ;
    logic               r_out_full;
    logic               r_out_empty;

    t_req             req;
    logic [XW-1:0]    wp_x, rp_x, occ_x;
    logic [OCC_W-1:0] occ;
    logic             occ_zero;
    logic             room_ok;
    logic             start_remove;
    logic             start_drain;
    logic             emit_simple;
    logic             emit;
    t_status          s_status;
    logic [OCC_W-1:0] s_occ;
    logic [OCC_W-1:0] e_occ;
    logic [PW-1:0]    wp_next, rp_next;
    logic             wr_en;
    logic             rd_en;
    logic [PW-1:0]    rd_addr;
    logic [ENTRY_WIDTH-1:0] rd_data;
    logic             cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    assign req = t_req'(i_req_type);

    assign wp_x  = XW'(r_wp);
    assign rp_x  = XW'(r_rp);
    assign occ_x = r_full     ? XW'(r_cap) :
                   (wp_x >= rp_x) ? (wp_x - rp_x) : (XW'(r_cap) + wp_x - rp_x);
    assign occ      = occ_x[OCC_W-1:0];
    assign occ_zero = (occ == '0);
    assign room_ok  = (i_reader_room >= ROOM_W'(occ));

    assign start_remove = (req == REQ_REMOVE) && !occ_zero;
    assign start_drain  = (req == REQ_DRAIN) && room_ok && !occ_zero;
    assign emit_simple  = i_cmd.accept && !start_remove && !start_drain;
    assign emit         = emit_simple || i_cmd.emit_entry;

    assign o_status.slot_free    = !r_out_valid || i_out_ready;
    assign o_status.start_remove = start_remove;
    assign o_status.start_drain  = start_drain;
    assign o_status.drain_last   = (r_cnt == OCC_W'(1));

    assign wp_next = f_next(r_wp, r_cap);
    assign rp_next = f_next(r_rp, r_cap);

    // result of a request that carries no entry, state as it stands after it
    always_comb begin
        s_status = ST_OK;
        s_occ    = occ;
        unique case (req)
            REQ_INSERT: begin
                s_status = r_full ? ST_OVERWRITE : ST_OK;
                s_occ    = r_full ? r_cap : occ + OCC_W'(1);
            end
            REQ_REMOVE: begin
                if (occ_zero) s_status = ST_EMPTY;
            end
            REQ_DRAIN: begin
                if (!room_ok) s_status = ST_NO_ROOM;
            end
            REQ_RESET: begin
                s_occ = '0;
            end
            default: begin
                s_status = ST_OK;
            end
        endcase
    end

    // pointers are already final when an entry is handed out
    assign e_occ = occ;

    always_comb begin
        n_cap  = r_cap;
        n_wp   = r_wp;
        n_rp   = r_rp;
        n_full = r_full;
        n_da   = r_da;
        n_cnt  = r_cnt;
        if (cfg_wr) begin
            if (i_capacity == '0) begin
                n_cap = CAP_W'(1);
            end else if (XW'(i_capacity) > XW'(DEPTH)) begin
                n_cap = CAP_W'(DEPTH);
            end else begin
                n_cap = i_capacity;
            end
            n_wp   = '0;
            n_rp   = '0;
            n_full = 1'b0;
        end else if (i_cmd.accept) begin
            unique case (req)
                REQ_INSERT: begin
                    n_wp = wp_next;
                    if (r_full) begin
                        n_rp   = rp_next;
                        n_full = (wp_next == rp_next);
                    end else begin
                        n_full = (wp_next == r_rp);
                    end
                end
                REQ_REMOVE: begin
                    if (start_remove) begin
                        n_rp   = rp_next;
                        n_full = 1'b0;
                    end
                end
                REQ_DRAIN: begin
                    if (start_drain) begin
                        n_da   = rp_next;
                        n_cnt  = occ;
                        n_wp   = '0;
                        n_rp   = '0;
                        n_full = 1'b0;
                    end
                end
                REQ_RESET: begin
                    n_wp   = '0;
                    n_rp   = '0;
                    n_full = 1'b0;
                end
                default: begin
                    n_wp = r_wp;
                end
            endcase
        end else if (i_cmd.drain_step) begin
            n_da  = f_next(r_da, r_cap);
            n_cnt = r_cnt - OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_INIT;
            r_wp   <= '0;
            r_rp   <= '0;
            r_full <= 1'b0;
            r_da   <= '0;
            r_cnt  <= '0;
        end else begin
            r_cap  <= n_cap;
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_full <= n_full;
            r_da   <= n_da;
            r_cnt  <= n_cnt;
        end
    end

    assign wr_en   = i_cmd.accept && (req == REQ_INSERT);
    assign rd_en   = (i_cmd.accept && (start_remove || start_drain)) || i_cmd.drain_step;
    assign rd_addr = i_cmd.drain_step ? r_da : r_rp;

    ort_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (i_entry_in[ENTRY_WIDTH-1:0]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_entry) begin
            r_entry_out   <= ENTRY_W'(rd_data);
            r_entry_valid <= 1'b1;
            r_last        <= i_cmd.entry_last;
            r_status      <= ST_OK;
            r_occ         <= e_occ;
            r_out_full    <= (e_occ == r_cap);
            r_out_empty   <= (e_occ == '0);
        end else if (emit_simple) begin
            r_entry_out   <= '0;
            r_entry_valid <= 1'b0;
            r_last        <= 1'b1;
            r_status      <= s_status;
            r_occ         <= s_occ;
            r_out_full    <= (s_occ == r_cap);
            r_out_empty   <= (s_occ == '0);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_out   = r_entry_out;
    assign o_entry_valid = r_entry_valid;
    assign o_last        = r_last;
    assign o_status_code = r_status;
    assign o_occupancy   = r_occ;
    assign o_is_full     = r_out_full;
    assign o_is_empty    = r_out_empty;

endmodule

// ===== hdl/ort_controller.sv =====
module ort_controller import ort_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctl_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_REMOVE = 3'b010,
        S_DRAIN  = 3'b100
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE) && i_status.slot_free;

    always_comb begin
        n_state          = r_state;
        o_cmd.accept     = 1'b0;
        o_cmd.emit_entry = 1'b0;
        o_cmd.entry_last = 1'b0;
        o_cmd.drain_step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.slot_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.start_remove) begin
                        n_state = S_REMOVE;
                    end else if (i_status.start_drain) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_REMOVE: begin
                // store data arrived the cycle after the read
                if (i_status.slot_free) begin
                    o_cmd.emit_entry = 1'b1;
                    o_cmd.entry_last = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_entry = 1'b1;
                    o_cmd.entry_last = i_status.drain_last;
                    if (i_status.drain_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.drain_step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/overwriting_ring_buffer_core.sv =====
// channel   direction  handshake                   payload
// cfg       in         i_cfg_valid / o_cfg_ready   i_capacity
// request   in         i_in_valid / o_in_ready     i_req_type, i_entry_in, i_reader_room
// result    out        o_out_valid / i_out_ready   o_entry_out .. o_is_empty
//
// insert, reset and any refused or empty request: result written straight into the output register
// remove: the store has one registered read port, so the entry goes out from the remove state
// drain of n entries: one store read per entry on that same port
// a new request is taken while the last result waits only if that result leaves this cycle
// synchronous active-low reset clears pointers and sets capacity to 64 (or DEPTH if smaller)
// the entry store has no reset; every slot read has been written since the last clear
`include "assert_macros.svh"

module overwriting_ring_buffer_core import ort_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_W-1:0]    i_capacity,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [ENTRY_W-1:0]  i_entry_in,
    input  logic [ROOM_W-1:0]   i_reader_room,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ENTRY_W-1:0]  o_entry_out,
    output logic                o_entry_valid,
    output logic                o_last,
    output logic [STATUS_W-1:0] o_status,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic                o_is_full,
    output logic                o_is_empty
);

    t_ctl_cmd   cmd;
    t_dp_status dp_status;

    ort_controller u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    ort_datapath #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_capacity    (i_capacity),
        .i_req_type    (i_req_type),
        .i_entry_in    (i_entry_in),
        .i_reader_room (i_reader_room),
        .i_cmd         (cmd),
        .o_status      (dp_status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entry_out   (o_entry_out),
        .o_entry_valid (o_entry_valid),
        .o_last        (o_last),
        .o_status_code (o_status),
        .o_occupancy   (o_occupancy),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

    `ASSERT_SAME(a_accept_free, i_clk, i_rst_n, cmd.accept || cmd.emit_entry,
        dp_status.slot_free, "result written over one not yet taken")
    `ASSERT_SAME(a_overwrite_full, i_clk, i_rst_n,
        o_out_valid && (o_status == ST_OVERWRITE), o_is_full && !o_is_empty,
        "overwriting insert left the queue not full")
    `ASSERT_SAME(a_no_entry_zero, i_clk, i_rst_n, o_out_valid && !o_entry_valid,
        (o_entry_out == '0) && o_last, "result without entry carries data")
    `ASSERT_NEXT(a_drain_goes_on, i_clk, i_rst_n, cmd.drain_step,
        !o_in_ready, "request taken in the middle of a drain")

endmodule
